// File: rtl/pnea_pkg.sv
`default_nettype none
package pnea_pkg;

  // Command codes carried by an input word
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [8:0] DIM_RESET = 9'd256;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam logic [17:0] ONE_Q16 = 18'd65536;

  localparam int DEF_MAX_PIXELS = 65536;
  localparam int CHANNELS = 3;
  // channels actually used by the datapath
  localparam int NCH = (CHANNELS < 3) ? CHANNELS : 3;
  localparam logic [1:0] LAST_CH = 2'(NCH - 1);

  // front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPW = 2;

  // Word handed from the front to the back through the queue
  typedef struct packed {
    logic             cmd;
    logic [15:0]      idx;
    logic [35:0]      den;
    logic [2:0][35:0] sq;
  } job_t;

  // Number of compare-subtract steps that reduce a 16-bit index modulo m
  function automatic int red_steps(input int m);
    longint mm;
    int     n;
    mm = longint'(m);
    n  = 0;
    for (int i = 0; i <= 16; i++) begin
      if ((mm << i) <= 64'd65535) n = i + 1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/per_pixel_normalized_error_accumulator.sv
`default_nettype none
// Per-pixel normalized squared-error accumulator. Accumulate words map a sample to a
// pixel, add sum over channels of (pred-target)^2/T^2 (T = summed target, 1.0 if zero)
// to that pixel's Q16.16 entry with saturation and return the new sum; read words
// return one entry. A two-stage front computes coordinates and squares and feeds a
// four-word queue; the back works on one word at a time. For an accumulate word the
// back runs a bit-serial divider per channel, one quotient bit per cycle; a channel
// whose term clips skips the divider. Index reduction runs only for a store depth
// below 65536. After reset the store is cleared one entry a cycle while full stays
// high; configuration writes are taken at any time and must only be made while idle.
module per_pixel_normalized_error_accumulator #(
  parameter int MAX_PIXELS = pnea_pkg::DEF_MAX_PIXELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [16:0] x_norm,
  input  wire logic [16:0] y_norm,
  input  wire logic [15:0] target_red,
  input  wire logic [15:0] target_green,
  input  wire logic [15:0] target_blue,
  input  wire logic [17:0] pred_red,
  input  wire logic [17:0] pred_green,
  input  wire logic [17:0] pred_blue,
  input  wire logic [15:0] read_pixel,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      pixel_addr,
  output logic [31:0]      error_sum,
  output logic             saturated,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import pnea_pkg::*;

  logic [8:0] image_width;
  logic [8:0] image_height;
  logic       clearing;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  job_t       q_in;
  job_t       q_out;
  logic       res_valid;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  pnea_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .x_norm       (x_norm),
    .y_norm       (y_norm),
    .target_red   (target_red),
    .target_green (target_green),
    .target_blue  (target_blue),
    .pred_red     (pred_red),
    .pred_green   (pred_green),
    .pred_blue    (pred_blue),
    .read_pixel   (read_pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .clearing     (clearing),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_word       (q_in)
  );

  pnea_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_out),
    .empty     (q_empty)
  );

  pnea_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_out),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_index (pixel_addr),
    .res_sum   (error_sum),
    .res_sat   (saturated)
  );

  assign empty = !res_valid;

  // no word taken while the store is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(push && !full))
    else $error("input word accepted during store clear");

  // back pulls from the queue only when it holds a word
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a waiting result word holds until it is taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(error_sum) && $stable(pixel_addr)))
    else $error("pending result word changed before it was taken");

endmodule
`default_nettype wire

// File: rtl/pnea_ram.sv
`default_nettype none
module pnea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/pnea_fifo.sv
`default_nettype none
module pnea_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pnea_pkg::job_t push_word,
  output logic               full,
  input  wire logic          pop,
  output pnea_pkg::job_t     pop_word,
  output logic               empty
);
  import pnea_pkg::*;

  job_t             entries [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QPW:0]     count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == (QPW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = entries[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_word;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/pnea_front.sv
`default_nettype none
module pnea_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [16:0] x_norm,
  input  wire logic [16:0] y_norm,
  input  wire logic [15:0] target_red,
  input  wire logic [15:0] target_green,
  input  wire logic [15:0] target_blue,
  input  wire logic [17:0] pred_red,
  input  wire logic [17:0] pred_green,
  input  wire logic [17:0] pred_blue,
  input  wire logic [15:0] read_pixel,
  input  wire logic [8:0]  image_width,
  input  wire logic [8:0]  image_height,
  input  wire logic        clearing,
  input  wire logic        q_full,
  output logic             q_push,
  output pnea_pkg::job_t   q_word
);
  import pnea_pkg::*;

  function automatic logic [8:0] clamp_dim(input logic [8:0] v);
    if (v == 9'd0) return 9'd1;
    if (v > 9'd256) return 9'd256;
    return v;
  endfunction

  // round half up of norm * (dim-1), clamped to dim-1
  function automatic logic [7:0] to_coord(input logic [16:0] norm, input logic [7:0] dm1);
    logic [25:0] p;
    logic [9:0]  pp;
    p  = 26'(norm) * 26'(dm1) + 26'd32768;
    pp = p[25:16];
    if (pp > {2'b00, dm1}) return dm1;
    return pp[7:0];
  endfunction

  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic [7:0]  wm1;
  logic [7:0]  hm1;
  logic        in_acc;
  logic        s1_adv;
  logic        s2_adv;

  logic [2:0][15:0] tgt;
  logic [2:0][17:0] prd;
  logic [2:0][17:0] mag;
  logic [17:0]      total;

  // stage 1 registers
  logic             s1_valid;
  logic             s1_cmd;
  logic [7:0]       s1_px;
  logic [7:0]       s1_py;
  logic [15:0]      s1_read;
  logic [17:0]      s1_total;
  logic [2:0][17:0] s1_mag;

  // stage 2 registers
  logic             s2_valid;
  job_t             s2_word;
  logic [16:0]      lin_idx;

  assign w_eff = clamp_dim(image_width);
  assign h_eff = clamp_dim(image_height);
  assign wm1   = 8'(w_eff - 9'd1);
  assign hm1   = 8'(h_eff - 9'd1);

  assign s2_adv = !s2_valid || !q_full;
  assign s1_adv = !s1_valid || s2_adv;
  assign full   = !s1_adv || clearing;
  assign in_acc = push && !full;

  assign tgt = {target_blue, target_green, target_red};
  assign prd = {pred_blue, pred_green, pred_red};

  // per channel error magnitude and summed target
  always_comb begin
    logic signed [18:0] d;
    total = '0;
    for (int c = 0; c < 3; c++) begin
      d = $signed({prd[c][17], prd[c]}) - $signed({3'b000, tgt[c]});
      mag[c] = d[18] ? 18'(-d) : d[17:0];
    end
    for (int c = 0; c < NCH; c++) total = total + 18'(tgt[c]);
    if (total == '0) total = ONE_Q16;
  end

  // stage 1: coordinates, target sum, magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_acc;
    end
    if (s1_adv && in_acc) begin
      s1_cmd   <= cmd;
      s1_px    <= to_coord(x_norm, wm1);
      s1_py    <= to_coord(y_norm, hm1);
      s1_read  <= read_pixel;
      s1_total <= total;
      s1_mag   <= mag;
    end
  end

  assign lin_idx = 17'(s1_py) * 17'(w_eff) + 17'(s1_px);

  // stage 2: linear index and squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
    if (s2_adv && s1_valid) begin
      s2_word.cmd <= s1_cmd;
      s2_word.idx <= (s1_cmd == CMD_READ) ? s1_read : lin_idx[15:0];
      s2_word.den <= 36'(s1_total) * 36'(s1_total);
      for (int c = 0; c < 3; c++) s2_word.sq[c] <= 36'(s1_mag[c]) * 36'(s1_mag[c]);
    end
  end

  assign q_push = s2_valid;
  assign q_word = s2_word;

endmodule
`default_nettype wire

// File: rtl/pnea_back.sv
`default_nettype none
module pnea_back #(
  parameter int MAX_PIXELS = pnea_pkg::DEF_MAX_PIXELS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire pnea_pkg::job_t q_word,
  output logic                clearing,
  output logic                res_valid,
  input  wire logic           res_pop,
  output logic [15:0]         res_index,
  output logic [31:0]         res_sum,
  output logic                res_sat
);
  import pnea_pkg::*;

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int RSTEPS = red_steps(MAX_PIXELS);
  localparam logic [3:0] KTOP = (RSTEPS > 0) ? 4'(RSTEPS - 1) : 4'd0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_ADDR, S_RWAIT,
    S_DSTART, S_DIV, S_ADD, S_WRITE, S_OUT
  } state_t;

  state_t        state;
  job_t          job;
  logic [15:0]   red_val;
  logic [3:0]    k;
  logic [AW-1:0] clr_addr;
  logic [31:0]   acc;
  logic          sat;
  logic [1:0]    ch;
  logic [35:0]   rem;
  logic [31:0]   dlo;
  logic [31:0]   q;
  logic [4:0]    cnt;
  logic [31:0]   term;

  logic [AW+15:0] slot_ext;
  logic [AW-1:0]  slot;
  logic [36:0]    mod_sh;
  logic [52:0]    dvd;
  logic           over;
  logic [36:0]    rs;
  logic           ge;
  logic [36:0]    rdiff;
  logic [32:0]    sum33;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  // store address after reduction modulo the store depth
  assign slot_ext = {{AW{1'b0}}, red_val};
  assign slot     = slot_ext[AW-1:0];
  assign mod_sh   = 37'(MAX_PIXELS) << k;

  // dividend = e^2 * 2^16 + den/2; quotient overflow test against den * 2^32
  assign dvd   = {1'b0, job.sq[ch], 16'h0000} + 53'(job.den >> 1);
  assign over  = {16'h0000, dvd} >= {1'b0, job.den, 32'h0000_0000};
  assign rs    = {rem, dlo[31]};
  assign ge    = rs >= {1'b0, job.den};
  assign rdiff = rs - {1'b0, job.den};
  assign sum33 = {1'b0, acc} + {1'b0, term};

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign clearing = (state == S_CLEAR);

  assign ram_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : slot;
  assign ram_wdata = (state == S_CLEAR) ? 32'h0 : acc;

  pnea_ram #(
    .WIDTH (32),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // sequencer: reduce index, read, divide and write back (accumulate), emit word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop && (state != S_OUT)) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_PIXELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            job     <= q_word;
            red_val <= q_word.idx;
            k       <= KTOP;
            state   <= (RSTEPS > 0) ? S_REDUCE : S_ADDR;
          end
        end
        S_REDUCE: begin
          if ({21'h0, red_val} >= mod_sh) red_val <= red_val - mod_sh[15:0];
          if (k == 4'd0) state <= S_ADDR;
          else k <= k - 4'd1;
        end
        S_ADDR: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          acc <= ram_rdata;
          sat <= 1'b0;
          ch  <= 2'd0;
          state <= (job.cmd == CMD_READ) ? S_OUT : S_DSTART;
        end
        S_DSTART: begin
          if (over) begin
            term  <= SUM_MAX;
            sat   <= 1'b1;
            state <= S_ADD;
          end else begin
            rem   <= 36'(dvd[52:32]);
            dlo   <= dvd[31:0];
            cnt   <= 5'd31;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          rem <= ge ? rdiff[35:0] : rs[35:0];
          q   <= {q[30:0], ge};
          dlo <= {dlo[30:0], 1'b0};
          if (cnt == 5'd0) begin
            term  <= {q[30:0], ge};
            state <= S_ADD;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_ADD: begin
          if (sum33[32]) begin
            acc <= SUM_MAX;
            sat <= 1'b1;
          end else begin
            acc <= sum33[31:0];
          end
          if (ch == LAST_CH) state <= S_WRITE;
          else begin
            ch    <= ch + 2'd1;
            state <= S_DSTART;
          end
        end
        S_WRITE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || res_pop) begin
            res_valid <= 1'b1;
            res_index <= job.idx;
            res_sum   <= acc;
            res_sat   <= (job.cmd == CMD_READ) ? 1'b0 : sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import pnea_pkg::*;

  // register index past the end of the list; the block drops it
  localparam logic [1:0] REG_SPARE = 2'd2;

  typedef struct {
    logic        cmd;
    logic [16:0] x;
    logic [16:0] y;
    logic [15:0] tgt [3];
    logic [17:0] prd [3];
    logic [15:0] rpix;
  } sample_t;

  typedef struct {
    logic [15:0] idx;
    logic [31:0] sum;
    logic        sat;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready, saturated;
  logic cmd = CMD_ACCUM;
  logic [16:0] x_norm = '0, y_norm = '0;
  logic [15:0] target_red = '0, target_green = '0, target_blue = '0;
  logic [17:0] pred_red = '0, pred_green = '0, pred_blue = '0;
  logic [15:0] read_pixel = '0;
  logic [15:0] pixel_addr;
  logic [31:0] error_sum;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_WIDTH;
  logic [8:0] cfg_data = '0;

  // predictor state
  logic [31:0] err_mem [65536];
  logic [8:0] width_reg = DIM_RESET, height_reg = DIM_RESET;
  pix_result_t pending_sums [$];
  int touched [$];
  int errors = 0;

  // traffic shaping
  bit calm = 0;
  int hold_cycles = 0;
  int pop_gap = 0;

  per_pixel_normalized_error_accumulator dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .x_norm(x_norm), .y_norm(y_norm),
    .target_red(target_red), .target_green(target_green), .target_blue(target_blue),
    .pred_red(pred_red), .pred_green(pred_green), .pred_blue(pred_blue),
    .read_pixel(read_pixel), .empty(empty), .pop(pop),
    .pixel_addr(pixel_addr), .error_sum(error_sum), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int eff_dim(input logic [8:0] v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // round half up of norm*(dim-1), clamped to the last pixel
  function automatic int pix_coord(input logic [16:0] norm, input int dim);
    longint p;
    p = (longint'(norm) * (dim - 1) + 32768) >>> 16;
    if (p > dim - 1) p = dim - 1;
    return int'(p);
  endfunction

  // apply one word to the error image and return the resulting sum
  function automatic pix_result_t apply_sample(input sample_t s);
    pix_result_t r;
    int w, h, idx;
    longint unsigned total, den, num, term, acc, mag;
    longint ev;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    if (s.cmd == CMD_READ) begin
      r.idx = s.rpix;
      r.sum = err_mem[s.rpix];
      r.sat = 1'b0;
      return r;
    end
    idx = pix_coord(s.y, h) * w + pix_coord(s.x, w);
    total = 0;
    for (int c = 0; c < NCH; c++) total += 64'(s.tgt[c]);
    if (total == 0) total = 65536;
    den = total * total;
    acc = 64'(err_mem[idx % 65536]);
    r.sat = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      ev = longint'($signed(s.prd[c])) - longint'(s.tgt[c]);
      mag = (ev < 0) ? -ev : ev;
      num = mag * mag * 65536;
      term = (num + den / 2) / den;
      if (term > 64'hFFFF_FFFF) begin
        term = 64'hFFFF_FFFF;
        r.sat = 1'b1;
      end
      acc += term;
      if (acc > 64'hFFFF_FFFF) begin
        acc = 64'hFFFF_FFFF;
        r.sat = 1'b1;
      end
    end
    err_mem[idx % 65536] = acc[31:0];
    r.idx = idx[15:0];
    r.sum = acc[31:0];
    if (touched.size() < 512) touched = {touched, idx};
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // compare each popped word with the oldest prediction
  always @(posedge clk) begin
    pix_result_t want;
    if (!rst && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        report("unexpected word", longint'(pixel_addr), 64'sd0);
      end else begin
        want = pending_sums.pop_front();
        if (pixel_addr !== want.idx)
          report("pixel_addr", longint'(pixel_addr), longint'(want.idx));
        if (error_sum !== want.sum)
          report("error_sum", longint'(error_sum), longint'(want.sum));
        if (saturated !== want.sat)
          report("saturated", longint'(saturated), longint'(want.sat));
      end
      pop_gap = calm ? 0 : int'($urandom_range(0, 14));
    end
  end

  // receiver: random gaps, plus long hold-offs when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else if (pop_gap > 0) begin
        pop <= 1'b0;
        pop_gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // offer one word; push is left high so back-to-back words need no dip
  task automatic send_word(input sample_t s);
    int gap;
    gap = calm ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= s.cmd;
    x_norm <= s.x;
    y_norm <= s.y;
    target_red <= s.tgt[0];
    target_green <= s.tgt[1];
    target_blue <= s.tgt[2];
    pred_red <= s.prd[0];
    pred_green <= s.prd[1];
    pred_blue <= s.prd[2];
    read_pixel <= s.rpix;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_sums = {pending_sums, apply_sample(s)};
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] ri, input logic [8:0] v);
    cfg_index <= ri;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (ri == REG_WIDTH) width_reg = v;
    else if (ri == REG_HEIGHT) height_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sample_t accum(input int x, input int y, input int t0, input int t1,
                                    input int t2, input int p0, input int p1, input int p2);
    sample_t s;
    s.cmd = CMD_ACCUM;
    s.x = 17'(x);
    s.y = 17'(y);
    s.tgt[0] = 16'(t0); s.tgt[1] = 16'(t1); s.tgt[2] = 16'(t2);
    s.prd[0] = 18'(p0); s.prd[1] = 18'(p1); s.prd[2] = 18'(p2);
    s.rpix = 16'($urandom);
    return s;
  endfunction

  function automatic sample_t read_of(input int p);
    sample_t s;
    s = accum($urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
    s.cmd = CMD_READ;
    s.rpix = 16'(p);
    return s;
  endfunction

  function automatic sample_t random_word();
    sample_t s;
    int mode;
    if ($urandom_range(0, 99) < 25) begin
      if (touched.size() > 0 && $urandom_range(0, 9) < 7)
        return read_of(touched[$urandom_range(0, touched.size() - 1)]);
      return read_of($urandom_range(0, 65535));
    end
    s = accum(0, 0, 0, 0, 0, 0, 0, 0);
    s.x = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                      : 17'($urandom_range(0, 65536));
    s.y = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                      : 17'($urandom_range(0, 65536));
    mode = $urandom_range(0, 9);
    for (int c = 0; c < 3; c++) begin
      if (mode == 0) s.tgt[c] = '0;
      else if (mode == 1) s.tgt[c] = 16'($urandom_range(0, 3));
      else s.tgt[c] = 16'($urandom);
      case ($urandom_range(0, 5))
        0: s.prd[c] = 18'($urandom);
        1, 2: s.prd[c] = 18'(int'(s.tgt[c]) + $urandom_range(0, 512) - 256);
        default: s.prd[c] = 18'($urandom_range(0, 131072) - 65536);
      endcase
    end
    return s;
  endfunction

  // directed: field extremes, rounding, zero target, clipping, reads, 3x2 image
  task automatic test_directed();
    send_word(accum(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(accum(65536, 65536, 65535, 65535, 65535, 65536, -65536, 0));
    send_word(accum(131071, 131071, 1, 0, 0, -131072, 131071, 65536));
    send_word(accum(128, 128, 100, 200, 300, 100, 200, 300));
    send_word(accum(127, 129, 0, 0, 0, 65536, -65536, 1));
    send_word(accum(32768, 32768, 0, 1, 0, 65536, 65536, 65536));
    repeat (3) send_word(accum(32768, 32768, 1, 0, 0, -65536, -65536, -65536));
    send_word(read_of(255 * 256 + 255));
    send_word(read_of(0));
    send_word(read_of(65535));
    send_word(read_of(128 * 256 + 128));
    send_word(read_of(12345));
    drain();
    write_reg(REG_WIDTH, 9'd3);
    write_reg(REG_HEIGHT, 9'd2);
    write_reg(REG_SPARE, 9'd7);
    send_word(accum(32768, 32768, 5, 5, 5, 0, 0, 0));
    send_word(accum(32767, 65536, 40000, 0, 0, 0, 20000, 0));
    send_word(accum(65536, 0, 7, 8, 9, 70000, -70000, 9));
    send_word(read_of(4));
    send_word(read_of(100));
    drain();
  endtask

  // random traffic across several image sizes, extremes included
  task automatic test_random();
    int dims [8][2] = '{'{256, 256}, '{1, 1}, '{0, 511}, '{257, 0},
                        '{7, 5}, '{16, 16}, '{2, 256}, '{256, 3}};
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 8) begin
        write_reg(REG_WIDTH, 9'(dims[ph][0]));
        write_reg(REG_HEIGHT, 9'(dims[ph][1]));
      end else begin
        write_reg(REG_WIDTH, 9'($urandom_range(0, 511)));
        write_reg(REG_HEIGHT, 9'($urandom_range(0, 511)));
      end
      touched.delete();
      calm = (ph % 3 == 1);
      repeat (190) send_word(random_word());
      drain();
    end
    calm = 0;
  endtask

  // stall the receiver long enough that the block backs up and raises full
  task automatic test_backpressure();
    write_reg(REG_WIDTH, 9'd4);
    write_reg(REG_HEIGHT, 9'd4);
    calm = 1;
    hold_cycles = 1500;
    repeat (14) send_word(random_word());
    calm = 0;
    drain();
  endtask

  initial begin
    for (int i = 0; i < 65536; i++) err_mem[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
